### rtl/core/cpc_pkg.sv
// Shared types and constants for the cyclic polynomial convolution core.
// Used by cpc_mac, cyclic_poly_convolution_core and the bench; no other dependencies.
`default_nettype none

package cpc_pkg;

  // fixed field widths
  localparam int COEF_W    = 32;
  localparam int IDX_W     = 8;
  localparam int LEN_CFG_W = 9;

  // length register reset value and lower clamp
  localparam logic [LEN_CFG_W-1:0] LEN_RESET = 9'd256;
  localparam int MIN_LEN = 2;

  // request kinds
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  // incoming request
  typedef struct packed {
    action_t                    action;
    logic [IDX_W-1:0]           coef_index;
    logic signed [COEF_W-1:0]   coef_a;
    logic signed [COEF_W-1:0]   coef_b;
  } in_item_t;

  // outgoing result
  typedef struct packed {
    logic signed [COEF_W-1:0]   result_coef;
    logic [IDX_W-1:0]           result_index;
  } out_item_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // sequencer to multiply-accumulate control
  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctl_t;

endpackage

`default_nettype wire

### rtl/core/cyclic_poly_convolution_core.sv
// Cyclic convolution in Z[x]/(x^N - 1). A load request writes one coefficient of each
// operand. A read request for position k first reduces k mod N by repeated
// compare-and-subtract (floor(k / N) subtractions, at most 127), then walks all N
// coefficient pairs through one shared multiply-accumulate, one pair per cycle, bounded
// by the single read port of each coefficient store. Input is stalled for the whole
// read. The result sits in an output register so the next request can be taken while it
// waits. The stores are not cleared at reset: reading positions never loaded gives
// undefined coefficients.
// Depends on cpc_pkg, cpc_coef_store and cpc_mac.
`default_nettype none

module cyclic_poly_convolution_core
  import cpc_pkg::*;
#(
  parameter int MAX_LEN = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [LEN_CFG_W-1:0] cfg_data
);

  localparam int AW    = $clog2(MAX_LEN);
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int RW    = (LEN_W > IDX_W) ? LEN_W : IDX_W;
  localparam int CW    = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_LEN);
  localparam logic [CW-1:0] MIN_C = CW'(MIN_LEN);
  localparam logic [RW-1:0] MAX_R = RW'(MAX_LEN);

  logic [LEN_CFG_W-1:0] poly_length;
  state_t               state;
  state_t               state_next;
  logic [LEN_W-1:0]     n_len;
  logic [RW-1:0]        kk;
  logic [IDX_W-1:0]     k_idx;
  logic [AW-1:0]        cnt;
  logic [AW-1:0]        j;

  logic [CW-1:0]        pl_ext;
  logic [CW-1:0]        eff_c;
  logic [LEN_W-1:0]     eff_len;
  logic [RW-1:0]        n_ext;
  logic [LEN_W-1:0]     n_m1;
  logic [RW-1:0]        idx_ext;
  logic                 in_fire;
  logic                 load_en;
  logic                 read_go;
  logic                 kk_ge_n;
  logic                 last;
  logic                 load_out;
  mac_ctl_t             mac_ctl;
  logic                 mac_busy;
  logic [COEF_W-1:0]    rd_a;
  logic [COEF_W-1:0]    rd_b;
  logic [COEF_W-1:0]    acc;

  // length register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_length <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      poly_length <= cfg_data;
    end
  end

  // clamp length to the supported range
  always_comb begin
    pl_ext = CW'(poly_length);
    if (pl_ext < MIN_C) begin
      eff_c = MIN_C;
    end else if (pl_ext > MAX_C) begin
      eff_c = MAX_C;
    end else begin
      eff_c = pl_ext;
    end
    eff_len = eff_c[LEN_W-1:0];
  end

  // request decode
  assign in_fire = in_valid && !in_stall;
  assign idx_ext = RW'(in_data.coef_index);
  assign load_en = in_fire && (in_data.action == ACT_LOAD) && (idx_ext < MAX_R);
  assign read_go = in_fire && (in_data.action == ACT_READ);

  assign n_ext   = RW'(n_len);
  assign n_m1    = n_len - LEN_W'(1);
  assign kk_ge_n = kk >= n_ext;
  assign last    = LEN_W'(cnt) == n_m1;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next    = state;
    in_stall      = 1'b1;
    mac_ctl.clear = 1'b0;
    mac_ctl.issue = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        mac_ctl.clear = read_go;
        if (read_go) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (!kk_ge_n) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        mac_ctl.issue = 1'b1;
        if (last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy && (!out_valid || !out_stall)) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // position bookkeeping for the walk
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (read_go) begin
          kk    <= idx_ext;
          k_idx <= in_data.coef_index;
          n_len <= eff_len;
        end
      end
      ST_REDUCE: begin
        cnt <= '0;
        if (kk_ge_n) begin
          kk <= kk - n_ext;
        end else begin
          j <= kk[AW-1:0];
        end
      end
      ST_RUN: begin
        cnt <= cnt + AW'(1);
        if (j == '0) begin
          j <= n_m1[AW-1:0];
        end else begin
          j <= j - AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // coefficient stores
  cpc_coef_store #(
    .DEPTH (MAX_LEN),
    .AW    (AW),
    .DW    (COEF_W)
  ) u_store_a (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (idx_ext[AW-1:0]),
    .wr_data (in_data.coef_a),
    .rd_addr (cnt),
    .rd_data (rd_a)
  );

  cpc_coef_store #(
    .DEPTH (MAX_LEN),
    .AW    (AW),
    .DW    (COEF_W)
  ) u_store_b (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (idx_ext[AW-1:0]),
    .wr_data (in_data.coef_b),
    .rd_addr (j),
    .rd_data (rd_b)
  );

  // shared multiply-accumulate
  cpc_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .a    (rd_a),
    .b    (rd_b),
    .acc  (acc),
    .busy (mac_busy)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.result_coef  <= acc;
      out_data.result_index <= k_idx;
    end
  end

  // a new result only appears once the walk has drained
  a_rose_from_drain : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DRAIN)
    else $error("result presented outside drain");

  // nothing left in the pipeline when back in idle
  a_idle_empty : assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !mac_busy)
    else $error("multiply-accumulate busy in idle");

  // reduced position and second index stay inside the length
  a_run_in_range : assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> (kk < n_ext) && (LEN_W'(j) < n_len))
    else $error("index out of range during walk");

  // the walk ends with the last pair
  a_run_length : assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && last |=> state == ST_DRAIN)
    else $error("walk did not end after last pair");

endmodule

`default_nettype wire

### rtl/core/cpc_coef_store.sv
// Coefficient store: one write port, one read port with registered data.
// Stand-alone memory, no package dependency.
`default_nettype none

module cpc_coef_store #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/core/cpc_mac.sv
// Shared multiply-accumulate unit: registered product, 32-bit wrapping sum.
// Depends on cpc_pkg for widths and the control struct.
`default_nettype none

module cpc_mac
  import cpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mac_ctl_t          ctl,
  input  wire logic [COEF_W-1:0] a,
  input  wire logic [COEF_W-1:0] b,
  output logic      [COEF_W-1:0] acc,
  output logic                   busy
);

  logic              rd_vld;
  logic              prod_vld;
  logic [COEF_W-1:0] prod;

  // valid tracking for memory read and product stages
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_vld   <= ctl.issue;
      prod_vld <= rd_vld;
    end
  end

  // low half of the product, same for signed and unsigned operands
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prod <= a * b;
    end
  end

  // wrapping accumulator
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + prod;
    end
  end

  assign busy = rd_vld | prod_vld;

endmodule

`default_nettype wire

### bench/cyclic_poly_convolution_core_tb.sv
// Self-checking bench for cyclic_poly_convolution_core: coefficient loads, result reads,
// length setting changes, random idling and a long output hold-off.
// Depends on cpc_pkg and the core RTL.
`timescale 1ns / 100ps

module cyclic_poly_convolution_core_tb;
  import cpc_pkg::*;

  localparam int STORE_DEPTH   = 256;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 600;
  localparam int IDLE_LIMIT    = 5000;
  localparam int MAX_REPORTS   = 10;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [LEN_CFG_W-1:0] cfg_data = '0;

  // stimulus bookkeeping
  in_item_t    requests_queued[$];
  out_item_t   conv_results_due[$];
  int unsigned requests_pushed = 0;
  int unsigned requests_taken = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned out_wait = 0;
  bit          no_idle = 1'b0;
  bit          hold_request = 1'b0;

  // predictor state
  logic [COEF_W-1:0]    first_store[STORE_DEPTH];
  logic [COEF_W-1:0]    second_store[STORE_DEPTH];
  logic [LEN_CFG_W-1:0] len_setting = LEN_RESET;

  always #6 clk = ~clk;

  cyclic_poly_convolution_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // length in use, clamped to the supported range
  function automatic int unsigned active_length();
    int unsigned n;
    n = 32'(len_setting);
    if (n < MIN_LEN) n = MIN_LEN;
    if (n > STORE_DEPTH) n = STORE_DEPTH;
    return n;
  endfunction

  // coefficient k of the cyclic product, wrapped to 32 bits
  function automatic logic [COEF_W-1:0] conv_coef_at(logic [IDX_W-1:0] k);
    int unsigned n;
    int unsigned kk;
    int unsigned j;
    logic [COEF_W-1:0] acc;
    n = active_length();
    kk = k % n;
    acc = '0;
    for (int unsigned i = 0; i < n; i++) begin
      j = (kk + n - i) % n;
      acc = acc + first_store[i] * second_store[j];
    end
    return acc;
  endfunction

  // apply one accepted request to the predictor
  function automatic void predict_request(in_item_t req);
    out_item_t res;
    if (req.action == ACT_LOAD) begin
      if (req.coef_index < STORE_DEPTH) begin
        first_store[req.coef_index] = req.coef_a;
        second_store[req.coef_index] = req.coef_b;
      end
    end else begin
      res.result_coef = conv_coef_at(req.coef_index);
      res.result_index = req.coef_index;
      conv_results_due.push_back(res);
    end
  endfunction

  function automatic void report_mismatch(string what, logic [COEF_W-1:0] want,
                                          logic [COEF_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endfunction

  // compare one result with the oldest one due
  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (conv_results_due.size() == 0) begin
      report_mismatch("result with none due (index)", '0, COEF_W'(got.result_index));
    end else begin
      want = conv_results_due.pop_front();
      if (got.result_coef !== want.result_coef)
        report_mismatch("result_coef", want.result_coef, got.result_coef);
      if (got.result_index !== want.result_index)
        report_mismatch("result_index", COEF_W'(want.result_index),
                        COEF_W'(got.result_index));
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    logic took;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        predict_request(in_data);
        requests_taken++;
        send_gap = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (in_valid && !took) begin
        // payload held while stalled
      end else if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (requests_queued.size() != 0) begin
        in_data <= requests_queued.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor with random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
        out_wait = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        out_wait = HOLD_CYCLES;
      end
      if (out_wait != 0) begin
        out_stall <= 1'b1;
        out_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_length();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return 1;
      2: return 511;
      3: return $urandom_range(255, 300);
      4, 5: return $urandom_range(13, 40);
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  function automatic void push_load(int unsigned idx, logic [COEF_W-1:0] a,
                                    logic [COEF_W-1:0] b);
    in_item_t req;
    req.action = ACT_LOAD;
    req.coef_index = IDX_W'(idx);
    req.coef_a = a;
    req.coef_b = b;
    requests_queued.push_back(req);
    requests_pushed++;
  endfunction

  function automatic void push_read(int unsigned k);
    in_item_t req;
    req.action = ACT_READ;
    req.coef_index = IDX_W'(k);
    req.coef_a = $urandom;
    req.coef_b = $urandom;
    requests_queued.push_back(req);
    requests_pushed++;
  endfunction

  // wait until every request is taken and every result is back
  task automatic drain_block();
    do @(posedge clk);
    while (requests_taken != requests_pushed || conv_results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(logic [LEN_CFG_W-1:0] value);
    drain_block();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    len_setting = value;
  endtask

  // stimulus
  initial begin
    int unsigned n;
    int unsigned start;
    bit pressure_done;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset length: field extremes at both ends of the store, then fill the rest
    push_load(0, 32'h7fff_ffff, 32'h8000_0000);
    push_load(255, 32'h8000_0000, 32'hffff_ffff);
    push_load(1, 32'hffff_ffff, 32'h7fff_ffff);
    push_load(254, 32'h0, 32'h0);
    for (int i = 2; i < 254; i++) push_load(i, pick_coef(), pick_coef());
    push_read(0);
    push_read(255);
    push_read(128);

    // length below range, read positions beyond length
    write_length(0);
    push_read(0);
    push_read(1);
    push_read(255);
    // load beyond length is stored but unused
    push_load(5, $urandom, $urandom);
    push_read(3);
    push_load(1, 32'h8000_0000, 32'h8000_0000);
    push_read(254);
    write_length(1);
    push_read(7);
    // length above range, stores kept across changes
    write_length(511);
    push_read(200);
    write_length(257);
    push_read(17);
    write_length(256);
    push_read(5);
    write_length(2);
    push_read(254);

    // random phases, the first one under a long output hold-off
    start = requests_pushed;
    pressure_done = 1'b0;
    while (requests_pushed - start < RANDOM_ITEMS) begin
      write_length(LEN_CFG_W'(pressure_done ? pick_length() : 4));
      n = active_length();
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 3) != 0) begin
          // well-formed: fresh operands, then a few reads
          if (n <= 40) begin
            for (int unsigned i = 0; i < n; i++) push_load(i, pick_coef(), pick_coef());
          end else begin
            repeat (8) push_load($urandom_range(0, n - 1), pick_coef(), pick_coef());
          end
          repeat ($urandom_range(1, 4)) push_read($urandom_range(0, 255));
        end else begin
          // noise: loads anywhere in the store and reads anywhere
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 1) != 0)
              push_load($urandom_range(0, 255), pick_coef(), pick_coef());
            else
              push_read($urandom_range(0, 255));
          end
        end
      end
      if (!pressure_done) begin
        repeat (20) push_read($urandom_range(0, 255));
        hold_request = 1'b1;
        pressure_done = 1'b1;
      end
    end

    drain_block();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/cpc_pkg.sv
rtl/core/cpc_coef_store.sv
rtl/core/cpc_mac.sv
rtl/core/cyclic_poly_convolution_core.sv
bench/cyclic_poly_convolution_core_tb.sv
